FILE: sv/machining_time_estimator_core_defines.svh
// assertion macros for the machining time estimator
`ifndef MACHINING_TIME_ESTIMATOR_CORE_DEFINES_SVH
`define MACHINING_TIME_ESTIMATOR_CORE_DEFINES_SVH
// check a property on every rising clock edge outside reset
`define MTE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// check a property including during reset
`define MTE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

FILE: sv/mte_pkg.sv
// package: constants and controller/datapath interface types
`timescale 1ns / 1ps
package mte_pkg;
   localparam int COORD_BITS     = 31;
   localparam int TIME_FRAC_BITS = 24;
   localparam int SUM_BITS       = 64;
   localparam int FEED_BITS      = 32;
   localparam int SQRT_STEPS     = 32;
   localparam int DIV_STEPS      = SUM_BITS;
   localparam int STEP_BITS      = 7;
   localparam logic [FEED_BITS-1:0] RAPID_FLOOR   = 32'd1000000;
   localparam logic [FEED_BITS-1:0] RAPID_DEFAULT = 32'd10000000;

   typedef struct packed {
      logic load;       // latch input beat, compute squares
      logic sum_sq;     // add squared differences
      logic sqrt_init;
      logic sqrt_step;
      logic div_init;
      logic div_step;
      logic accumulate;
      logic clear;
   } mte_cmd_type;

   typedef struct packed {
      logic is_clear;
   } mte_status_type;
endpackage

FILE: sv/mte_datapath.sv
// datapath: position, feed, square root, divider and saturating totals
`timescale 1ns / 1ps
module mte_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  mte_pkg::mte_cmd_type       cmd,
   output mte_pkg::mte_status_type    status,
   input  logic [31:0]                csr_rapid_feed,
   input  logic                       req_command,
   input  logic                       req_rapid_select,
   input  logic                       req_has_x,
   input  logic signed [30:0]         req_x_value,
   input  logic                       req_has_y,
   input  logic signed [30:0]         req_y_value,
   input  logic                       req_has_z,
   input  logic signed [30:0]         req_z_value,
   input  logic                       req_has_feed,
   input  logic signed [31:0]         req_feed_value,
   output logic [63:0]                total_time,
   output logic [63:0]                rapid_time,
   output logic [63:0]                path_length
);
   import mte_pkg::*;

   logic signed [COORD_BITS-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [FEED_BITS-1:0] feed_ff, feed_in, rapid_ff, rapid_eff;
   logic [SUM_BITS-1:0] time_ff, rapidsum_ff, len_ff;
   logic cmd_ff, is_fast_ff;
   logic [SUM_BITS-1:0] sqx_ff, sqy_ff, sqz_ff;
   logic [SUM_BITS-1:0] rad_ff, root_ff, bit_ff;
   logic [SUM_BITS-1:0] quo_ff;
   logic [FEED_BITS:0] rem_ff;
   logic [SUM_BITS-1:0] dvd_ff;
   logic signed [COORD_BITS-1:0] nx, ny, nz;
   logic signed [COORD_BITS:0] dx, dy, dz;
   logic [COORD_BITS-1:0] ax, ay, az;
   logic [FEED_BITS-1:0] cur, fv;
   logic [SUM_BITS-1:0] trial, dt;
   logic [FEED_BITS:0] rem_sh;
   logic [SUM_BITS:0] s_len, s_time, s_rap;

   assign rapid_eff = (csr_rapid_feed <= RAPID_FLOOR) ? RAPID_DEFAULT : csr_rapid_feed;
   assign status.is_clear = cmd_ff;

   always_comb begin
      nx = req_has_x ? req_x_value[COORD_BITS-1:0] : pos_x_ff;
      ny = req_has_y ? req_y_value[COORD_BITS-1:0] : pos_y_ff;
      nz = req_has_z ? req_z_value[COORD_BITS-1:0] : pos_z_ff;
      dx = {nx[COORD_BITS-1], nx} - {pos_x_ff[COORD_BITS-1], pos_x_ff};
      dy = {ny[COORD_BITS-1], ny} - {pos_y_ff[COORD_BITS-1], pos_y_ff};
      dz = {nz[COORD_BITS-1], nz} - {pos_z_ff[COORD_BITS-1], pos_z_ff};
      ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
      ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
      az = dz[COORD_BITS] ? COORD_BITS'(-dz) : dz[COORD_BITS-1:0];
      cur = req_rapid_select ? rapid_eff : feed_ff;
      fv = req_feed_value;
      feed_in = cur;
      if (req_has_feed) begin
         if (fv != '0 && !fv[FEED_BITS-1]) feed_in = fv;
      end
      if (feed_in == '0) feed_in = rapid_eff;
      trial = root_ff + bit_ff;
      rem_sh = {rem_ff[FEED_BITS-1:0], dvd_ff[SUM_BITS-1]};
      dt = quo_ff;
      s_len = {1'b0, len_ff} + {1'b0, root_ff};
      s_time = {1'b0, time_ff} + {1'b0, dt};
      s_rap = {1'b0, rapidsum_ff} + {1'b0, dt};
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
         feed_ff <= rapid_eff;
         time_ff <= '0;
         rapidsum_ff <= '0;
         len_ff <= '0;
         cmd_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            cmd_ff <= req_command;
            if (!req_command) begin
               pos_x_ff <= nx;
               pos_y_ff <= ny;
               pos_z_ff <= nz;
               feed_ff <= feed_in;
               rapid_ff <= rapid_eff;
               sqx_ff <= SUM_BITS'(ax) * SUM_BITS'(ax);
               sqy_ff <= SUM_BITS'(ay) * SUM_BITS'(ay);
               sqz_ff <= SUM_BITS'(az) * SUM_BITS'(az);
            end
         end
         if (cmd.sum_sq) begin
            rad_ff <= sqx_ff + sqy_ff + sqz_ff;
            is_fast_ff <= (feed_ff >= rapid_ff);
         end
         if (cmd.sqrt_init) begin
            root_ff <= '0;
            bit_ff <= {2'b01, {(SUM_BITS-2){1'b0}}};
         end
         if (cmd.sqrt_step) begin
            if (rad_ff >= trial) begin
               rad_ff <= rad_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         // dividend = dist << frac; dist < 2^32 so fits 64 bits
         if (cmd.div_init) begin
            dvd_ff <= root_ff << TIME_FRAC_BITS;
            rem_ff <= '0;
            quo_ff <= '0;
         end
         if (cmd.div_step) begin
            dvd_ff <= dvd_ff << 1;
            if (rem_sh >= {1'b0, feed_ff}) begin
               rem_ff <= rem_sh - {1'b0, feed_ff};
               quo_ff <= {quo_ff[SUM_BITS-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[SUM_BITS-2:0], 1'b0};
            end
         end
         if (cmd.accumulate) begin
            len_ff <= s_len[SUM_BITS] ? '1 : s_len[SUM_BITS-1:0];
            time_ff <= s_time[SUM_BITS] ? '1 : s_time[SUM_BITS-1:0];
            if (is_fast_ff)
               rapidsum_ff <= s_rap[SUM_BITS] ? '1 : s_rap[SUM_BITS-1:0];
         end
      end
   end

   assign total_time = time_ff;
   assign rapid_time = rapidsum_ff;
   assign path_length = len_ff;
endmodule

FILE: sv/mte_controller.sv
// controller: runs one beat via sqrt, divide and accumulate, or a clear
`timescale 1ns / 1ps
module mte_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mte_pkg::mte_status_type status,
   output mte_pkg::mte_cmd_type    cmd
);
   import mte_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SUM  = 3'd1;
   localparam logic [2:0] S_SQRT = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_ACC  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic accept;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (status.is_clear) begin
               cmd.clear = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.sum_sq = 1'b1;
               cmd.sqrt_init = 1'b1;
               cnt_in = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_BITS'(SQRT_STEPS-1)) begin
               state_in = S_DIV;
               cnt_in = '0;
               cmd.sqrt_step = 1'b1;
            end
         end
         // a load step, then one quotient bit per cycle
         S_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '0) begin
               cmd.div_init = 1'b1;
            end else begin
               cmd.div_step = 1'b1;
               if (cnt_ff == STEP_BITS'(DIV_STEPS)) state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.accumulate = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

FILE: sv/machining_time_estimator_core.sv
// Machining time estimator top level.
// Input channel req_*: one NC block (or new-program command) per beat,
// valid/ready handshake. Result channel rsp_*: one beat per input beat with
// the running time, rapid time and path length after that block.
// csr_rapid_feed_we/csr_rapid_feed write the rapid rate register; write it
// only while the block is idle.
// A motion block passes a setup step (sum of squares), 32 square-root steps,
// the restoring divider and an accumulate step, then the result is held
// on rsp_* with rsp_valid high. A new-program command clears positions and
// totals and skips the square root and divider.
// One block is worked at a time: req_ready is high only when idle, so
// a new block is taken only after the last result has been accepted.
// Reset clears positions and totals and loads the feed from the rapid
// rate register. If the receiver stalls, the result stays on rsp_* and no
// new block is taken until it is accepted.
// The bit-serial square root and divider set the cycle count.
`timescale 1ns / 1ps
`include "machining_time_estimator_core_defines.svh"
module machining_time_estimator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_rapid_feed_we,
   input  logic [31:0]        csr_rapid_feed,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic               req_rapid_select,
   input  logic               req_has_x,
   input  logic signed [30:0] req_x_value,
   input  logic               req_has_y,
   input  logic signed [30:0] req_y_value,
   input  logic               req_has_z,
   input  logic signed [30:0] req_z_value,
   input  logic               req_has_feed,
   input  logic signed [31:0] req_feed_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_total_time,
   output logic [63:0]        rsp_rapid_time,
   output logic [63:0]        rsp_path_length
);
   import mte_pkg::*;

   mte_cmd_type cmd;
   mte_status_type status;
   logic [31:0] rapid_reg_ff;

   always_ff @(posedge clock) begin
      if (reset) rapid_reg_ff <= RAPID_DEFAULT;
      else if (csr_rapid_feed_we) rapid_reg_ff <= csr_rapid_feed;
   end

   mte_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .status(status), .cmd(cmd)
   );

   mte_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .csr_rapid_feed(rapid_reg_ff),
      .req_command(req_command), .req_rapid_select(req_rapid_select),
      .req_has_x(req_has_x), .req_x_value(req_x_value),
      .req_has_y(req_has_y), .req_y_value(req_y_value),
      .req_has_z(req_has_z), .req_z_value(req_z_value),
      .req_has_feed(req_has_feed), .req_feed_value(req_feed_value),
      .total_time(rsp_total_time), .rapid_time(rsp_rapid_time),
      .path_length(rsp_path_length)
   );

   `MTE_ASSERT(a_no_accept_busy, rsp_valid |-> !req_ready, "accept while result pending")
   `MTE_ASSERT(a_rapid_le_total, rsp_valid |-> (rsp_rapid_time <= rsp_total_time), "rapid > total")
   `MTE_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> $stable(rsp_path_length), "stall")
endmodule

FILE: test/machining_time_estimator_core_test.sv
// testbench for the machining time estimator core: directed and random nc blocks
`timescale 1ns / 1ps
module machining_time_estimator_core_test;
   import mte_pkg::*;

   localparam logic CMD_MOTION      = 1'b0;
   localparam logic CMD_NEW_PROGRAM = 1'b1;
   localparam longint CYCLE_LIMIT   = 2000000;
   localparam int     DRAIN_CYCLES  = 150;
   localparam int     HOLD_CYCLES   = 400;
   localparam logic signed [30:0] COORD_MAX = 31'sh3FFFFFFF;
   localparam logic signed [30:0] COORD_MIN = -31'sh40000000;

   typedef struct {
      logic              command;
      logic              rapid_select;
      logic              has_x;
      logic signed [30:0] x;
      logic              has_y;
      logic signed [30:0] y;
      logic              has_z;
      logic signed [30:0] z;
      logic              has_feed;
      logic signed [31:0] feed;
   } nc_block_type;

   typedef struct {
      logic [63:0] total_time;
      logic [63:0] rapid_time;
      logic [63:0] path_length;
   } totals_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_rapid_feed_we = 1'b0;
   logic [31:0] csr_rapid_feed = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_command = 1'b0;
   logic req_rapid_select = 1'b0;
   logic req_has_x = 1'b0;
   logic signed [30:0] req_x_value = '0;
   logic req_has_y = 1'b0;
   logic signed [30:0] req_y_value = '0;
   logic req_has_z = 1'b0;
   logic signed [30:0] req_z_value = '0;
   logic req_has_feed = 1'b0;
   logic signed [31:0] req_feed_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [63:0] rsp_total_time, rsp_rapid_time, rsp_path_length;

   machining_time_estimator_core dut (
      .clock(clock), .reset(reset),
      .csr_rapid_feed_we(csr_rapid_feed_we), .csr_rapid_feed(csr_rapid_feed),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_rapid_select(req_rapid_select),
      .req_has_x(req_has_x), .req_x_value(req_x_value),
      .req_has_y(req_has_y), .req_y_value(req_y_value),
      .req_has_z(req_has_z), .req_z_value(req_z_value),
      .req_has_feed(req_has_feed), .req_feed_value(req_feed_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_total_time(rsp_total_time), .rsp_rapid_time(rsp_rapid_time),
      .rsp_path_length(rsp_path_length)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic [31:0] rapid_reg = RAPID_DEFAULT;
   longint      at_x, at_y, at_z;
   logic [31:0] feed_now;
   logic [63:0] time_acc, rapid_acc, length_acc;

   totals_type expected_totals[$];
   int  errors = 0;
   bit  quiet = 0;
   bit  long_hold = 0;
   longint cycles = 0;

   function automatic logic [31:0] rapid_rate();
      return (rapid_reg <= RAPID_FLOOR) ? RAPID_DEFAULT : rapid_reg;
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] square_of_gap(input longint a, input longint b);
      longint d;
      logic [63:0] m;
      d = a - b;
      m = (d < 0) ? -d : d;
      return m * m;
   endfunction

   function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic void restart_program();
      at_x = 0; at_y = 0; at_z = 0;
      feed_now = rapid_rate();
      time_acc = 0; rapid_acc = 0; length_acc = 0;
   endfunction

   function automatic totals_type advance_estimate(input nc_block_type b);
      totals_type t;
      logic [31:0] rapid, prev, feed;
      longint nx, ny, nz;
      logic [63:0] span, q, r, dt;
      if (b.command == CMD_NEW_PROGRAM) begin
         restart_program();
      end else begin
         rapid = rapid_rate();
         nx = at_x; ny = at_y; nz = at_z;
         if (b.rapid_select) feed_now = rapid;
         if (b.has_x) nx = b.x;
         if (b.has_y) ny = b.y;
         if (b.has_z) nz = b.z;
         prev = feed_now;
         feed = prev;
         if (b.has_feed) begin
            if (b.feed > 0) feed = b.feed;
            else feed = (prev != 0) ? prev : rapid;
         end
         if (feed == 0) feed = rapid;
         feed_now = feed;
         span = floor_sqrt(square_of_gap(nx, at_x) + square_of_gap(ny, at_y)
                           + square_of_gap(nz, at_z));
         at_x = nx; at_y = ny; at_z = nz;
         length_acc = add_sat(length_acc, span);
         q = span / feed;
         r = span % feed;
         dt = (q << TIME_FRAC_BITS) + ((r << TIME_FRAC_BITS) / feed);
         if (feed >= rapid) rapid_acc = add_sat(rapid_acc, dt);
         time_acc = add_sat(time_acc, dt);
      end
      t.total_time = time_acc;
      t.rapid_time = rapid_acc;
      t.path_length = length_acc;
      return t;
   endfunction

   // drive one block; returns at the falling edge after the beat is taken
   task automatic send_block(input nc_block_type b);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_command <= b.command;
      req_rapid_select <= b.rapid_select;
      req_has_x <= b.has_x; req_x_value <= b.x;
      req_has_y <= b.has_y; req_y_value <= b.y;
      req_has_z <= b.has_z; req_z_value <= b.z;
      req_has_feed <= b.has_feed; req_feed_value <= b.feed;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_totals.push_back(advance_estimate(b));
      @(negedge clock);
   endtask

   function automatic nc_block_type motion(input int rs, input int hx, input int x,
                                           input int hy, input int y, input int hz,
                                           input int z, input int hf, input int f);
      nc_block_type b;
      b.command = CMD_MOTION; b.rapid_select = (rs[0] != 0);
      b.has_x = (hx[0] != 0); b.x = x[30:0];
      b.has_y = (hy[0] != 0); b.y = y[30:0];
      b.has_z = (hz[0] != 0); b.z = z[30:0];
      b.has_feed = (hf[0] != 0); b.feed = f;
      return b;
   endfunction

   function automatic nc_block_type new_program();
      nc_block_type b;
      b = motion($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
      b.command = CMD_NEW_PROGRAM;
      return b;
   endfunction

   function automatic nc_block_type random_block();
      nc_block_type b;
      int sel;
      b = motion(($urandom_range(0, 3) == 0) ? 1 : 0, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom_range(0, 1), $urandom);
      sel = $urandom_range(0, 9);
      // mostly short moves so time and length stay readable
      if (sel < 6) begin
         b.x = 31'($signed($urandom_range(0, 200000)) - 100000);
         b.y = 31'($signed($urandom_range(0, 200000)) - 100000);
         b.z = 31'($signed($urandom_range(0, 200000)) - 100000);
      end
      sel = $urandom_range(0, 9);
      if (sel < 5) b.feed = $urandom_range(1, 20000000);
      else if (sel == 5) b.feed = 0;
      else if (sel == 6) b.feed = -$signed($urandom_range(1, 1000));
      if ($urandom_range(0, 29) == 0) b = new_program();
      return b;
   endfunction

   // wait for idle, then write the rapid rate register
   task automatic write_rapid_rate(input logic [31:0] value);
      req_valid <= 1'b0;
      while (expected_totals.size() != 0) @(negedge clock);
      csr_rapid_feed <= value;
      csr_rapid_feed_we <= 1'b1;
      @(negedge clock);
      csr_rapid_feed_we <= 1'b0;
      rapid_reg = value;
   endtask

   // receiver side: random stall bursts, one long hold on request
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 0;
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      totals_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_totals.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing expected, expected none actual %0d",
                     $time, rsp_total_time);
         end else begin
            e = expected_totals.pop_front();
            check_field("total_time", e.total_time, rsp_total_time);
            check_field("rapid_time", e.rapid_time, rsp_rapid_time);
            check_field("path_length", e.path_length, rsp_path_length);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic test_reset_state();
      send_block(motion(0, 1, 1000, 1, 0, 0, 0, 0, 0));
      send_block(motion(0, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_coordinate_extremes();
      send_block(motion(0, 1, COORD_MAX, 1, COORD_MAX, 1, COORD_MAX, 1, 1000));
      send_block(motion(0, 1, COORD_MIN, 1, COORD_MIN, 1, COORD_MIN, 0, 0));
      send_block(motion(1, 1, 0, 0, 0, 1, COORD_MAX, 0, 0));
      send_block(motion(0, 0, 0, 1, -1, 0, 0, 1, 32'h7FFFFFFF));
   endtask

   task automatic test_feed_fallback();
      send_block(motion(0, 1, 5000, 0, 0, 0, 0, 1, 0));
      send_block(motion(0, 1, 9000, 0, 0, 0, 0, 1, 32'h80000000));
      send_block(motion(0, 1, 1, 0, 0, 0, 0, 1, -1));
      send_block(motion(0, 1, 7777, 1, 3333, 0, 0, 1, 1));
      send_block(motion(1, 1, 0, 0, 0, 0, 0, 1, -5));
      send_block(motion(1, 0, 0, 1, 123456, 0, 0, 1, 2000));
   endtask

   task automatic test_new_program();
      send_block(new_program());
      send_block(motion(0, 1, 3, 1, 4, 0, 0, 0, 0));
      send_block(new_program());
   endtask

   task automatic test_rapid_settings();
      logic [31:0] vals[6];
      vals = '{32'd1, RAPID_FLOOR, RAPID_FLOOR + 1, 32'hFFFFFFFF,
               $urandom_range(1000001, 50000000), RAPID_DEFAULT};
      foreach (vals[i]) begin
         write_rapid_rate(vals[i]);
         send_block(new_program());
         send_block(motion(1, 1, 400000, 1, -300000, 0, 0, 0, 0));
         send_block(motion(0, 1, 0, 0, 0, 1, 99, 1, vals[i]));
         send_block(motion(0, 1, 5, 0, 0, 0, 0, 1, 1500000));
      end
   endtask

   // slowest feed with corner to corner moves drives total time to its ceiling
   task automatic test_saturation();
      send_block(new_program());
      for (int i = 0; i < 310; i++)
         send_block(motion(0, 1, i[0] ? COORD_MAX : COORD_MIN, 1,
                           i[0] ? COORD_MAX : COORD_MIN, 1,
                           i[0] ? COORD_MAX : COORD_MIN, 1, 1));
      send_block(motion(1, 1, 0, 0, 0, 0, 0, 0, 0));
      send_block(new_program());
   endtask

   task automatic test_backpressure();
      long_hold = 1;
      for (int i = 0; i < 6; i++) send_block(random_block());
   endtask

   task automatic test_random_blocks(input int count);
      for (int i = 0; i < count; i++) send_block(random_block());
   endtask

   initial begin
      restart_program();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_state();
      test_coordinate_extremes();
      test_feed_fallback();
      test_new_program();
      test_rapid_settings();
      test_saturation();
      write_rapid_rate($urandom_range(1, 30000000));
      test_backpressure();
      test_random_blocks(200);
      write_rapid_rate(RAPID_DEFAULT);
      send_block(new_program());
      test_random_blocks(100);
      quiet = 1;
      test_random_blocks(60);
      req_valid <= 1'b0;
      while (expected_totals.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
